>>> src/four_function_calculator_keys_defines.svh
// Assertion macros shared by the calculator key-entry block.
`ifndef FOUR_FUNCTION_CALCULATOR_KEYS_DEFINES_SVH
`define FOUR_FUNCTION_CALCULATOR_KEYS_DEFINES_SVH

// Check that cons holds in the same cycle as cond.
`define FFCK_ASSERT_SAME(label, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after cond.
`define FFCK_ASSERT_NEXT(label, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

>>> src/ffck_pkg.sv
// Types, key codes and decode helpers of the calculator key-entry block.
package ffck_pkg;

	localparam logic [7:0] KEY_ZERO   = 8'h30;
	localparam logic [7:0] KEY_NINE   = 8'h39;
	localparam logic [7:0] KEY_PLUS   = 8'h2B;
	localparam logic [7:0] KEY_MINUS  = 8'h2D;
	localparam logic [7:0] KEY_TIMES  = 8'h2A;
	localparam logic [7:0] KEY_DIVIDE = 8'h2F;
	localparam logic [7:0] KEY_EQUALS = 8'h3D;
	localparam logic [7:0] KEY_CLEAR  = 8'h43;

	typedef enum logic [2:0] {
		OP_NONE = 3'd0,
		OP_ADD  = 3'd1,
		OP_SUB  = 3'd2,
		OP_MUL  = 3'd3,
		OP_DIV  = 3'd4
	} op_code_t;

	typedef enum logic [1:0] {
		ERR_NONE = 2'd0,
		ERR_DIV0 = 2'd1,
		ERR_OVF  = 2'd2
	} err_code_t;

	typedef enum logic [2:0] {
		KC_DIGIT,
		KC_OPER,
		KC_EQUALS,
		KC_CLEAR,
		KC_OTHER
	} key_kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_ITER,
		ST_PUSH,
		ST_FIN
	} ctl_state_t;

	typedef enum logic [3:0] {
		DP_NOP,
		DP_DIGIT,
		DP_CLEAR,
		DP_ADDSUB,
		DP_MUL_START,
		DP_DIV_START,
		DP_STEP,
		DP_MUL_END,
		DP_DIV_END,
		DP_DIVZERO,
		DP_PUSH
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic       clr_err;
		logic       capture;
		logic [3:0] digit;
		op_code_t   new_op;
	} dp_cmd_t;

	typedef struct packed {
		op_code_t pending;
		logic     entry_zero;
		logic     iter_done;
	} dp_status_t;

	function automatic key_kind_t key_kind(input logic [7:0] key);
		key_kind_t k;
		k = KC_OTHER;
		if (key >= KEY_ZERO && key <= KEY_NINE) begin
			k = KC_DIGIT;
		end else if (key == KEY_PLUS || key == KEY_MINUS || key == KEY_TIMES ||
				key == KEY_DIVIDE) begin
			k = KC_OPER;
		end else if (key == KEY_EQUALS) begin
			k = KC_EQUALS;
		end else if (key == KEY_CLEAR) begin
			k = KC_CLEAR;
		end
		return k;
	endfunction

	function automatic op_code_t key_op(input logic [7:0] key);
		op_code_t o;
		case (key)
			KEY_PLUS: o = OP_ADD;
			KEY_MINUS: o = OP_SUB;
			KEY_TIMES: o = OP_MUL;
			KEY_DIVIDE: o = OP_DIV;
			default: o = OP_NONE;
		endcase
		return o;
	endfunction

endpackage

>>> src/ffck_key_if.sv
// Key channel: one ASCII key code per transaction.
interface ffck_key_if;
	logic       valid;
	logic       ready;
	logic [7:0] key_code;

	modport source (output valid, output key_code, input ready);
	modport sink (input valid, input key_code, output ready);
endinterface

>>> src/ffck_res_if.sv
// Result channel: display, last result, error and pending operation.
interface ffck_res_if #(
	parameter int VALUE_BITS = 48
);
	logic                         valid;
	logic                         ready;
	logic signed [VALUE_BITS-1:0] display_value;
	logic signed [VALUE_BITS-1:0] recent_result;
	logic [1:0]                   error_status;
	logic [2:0]                   pending_op;

	modport source (output valid, output display_value, output recent_result,
		output error_status, output pending_op, input ready);
	modport sink (input valid, input display_value, input recent_result,
		input error_status, input pending_op, output ready);
endinterface

>>> src/ffck_ctrl.sv
// Controller state machine: sequences key handling and the result slot.
module ffck_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 key_valid,
	output logic                 key_ready,
	input  logic [7:0]           key_code,
	output logic                 res_valid,
	input  logic                 res_ready,
	output ffck_pkg::dp_cmd_t    cmd,
	input  ffck_pkg::dp_status_t status
);
	import ffck_pkg::*;

	ctl_state_t state_q, state_d;
	logic [7:0] key_q;
	logic       res_valid_q, res_valid_d;
	key_kind_t  kind;
	logic       oper;

	assign kind = key_kind(key_q);
	assign oper = (kind == KC_OPER);
	assign key_ready = (state_q == ST_IDLE);
	assign res_valid = res_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			res_valid_q <= res_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (key_valid && key_ready) begin
			key_q <= key_code;
		end
	end

	always_comb begin
		state_d     = state_q;
		res_valid_d = res_valid_q && !res_ready;
		cmd         = '0;
		cmd.op      = DP_NOP;
		cmd.digit   = 4'(key_q - KEY_ZERO);
		cmd.new_op  = key_op(key_q);
		case (state_q)
			ST_IDLE: begin
				if (key_valid) begin
					cmd.clr_err = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = ST_FIN;
				case (kind)
					KC_DIGIT: cmd.op = DP_DIGIT;
					KC_CLEAR: cmd.op = DP_CLEAR;
					KC_OPER, KC_EQUALS: begin
						if (oper) begin
							state_d = ST_PUSH;
						end
						case (status.pending)
							OP_ADD, OP_SUB: cmd.op = DP_ADDSUB;
							OP_MUL: begin
								cmd.op  = DP_MUL_START;
								state_d = ST_ITER;
							end
							OP_DIV: begin
								if (status.entry_zero) begin
									cmd.op = DP_DIVZERO;
								end else begin
									cmd.op  = DP_DIV_START;
									state_d = ST_ITER;
								end
							end
							default: cmd.op = DP_NOP;
						endcase
					end
					default: cmd.op = DP_NOP;
				endcase
			end
			ST_ITER: begin
				if (status.iter_done) begin
					cmd.op  = (status.pending == OP_MUL) ? DP_MUL_END : DP_DIV_END;
					state_d = oper ? ST_PUSH : ST_FIN;
				end else begin
					cmd.op = DP_STEP;
				end
			end
			ST_PUSH: begin
				cmd.op  = DP_PUSH;
				state_d = ST_FIN;
			end
			ST_FIN: begin
				// hold until the result slot is free
				if (!res_valid_q || res_ready) begin
					cmd.capture = 1'b1;
					res_valid_d = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

>>> src/ffck_dp.sv
// Datapath: entry and operand registers, saturating arithmetic, shared
// shift-add multiplier and restoring divider, result register.
module ffck_dp #(
	parameter int VALUE_BITS    = 48,
	parameter int FRACTION_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ffck_pkg::dp_cmd_t            cmd,
	output ffck_pkg::dp_status_t         status,
	output logic signed [VALUE_BITS-1:0] display_value,
	output logic signed [VALUE_BITS-1:0] recent_result,
	output logic [1:0]                   error_status,
	output logic [2:0]                   pending_op
);
	import ffck_pkg::*;

	localparam int W  = VALUE_BITS;
	localparam int F  = FRACTION_BITS;
	localparam int CW = $clog2(W + F + 1);
	localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

	logic [W-1:0]   entry_q, stored_q, hold_q;
	op_code_t       pend_q;
	err_code_t      err_q;
	logic [W-1:0]   opnd_q, rem_q;
	logic [2*W-1:0] work_q;
	logic           sign_q;
	logic [CW-1:0]  cnt_q;
	logic [W-1:0]   disp_q, last_q;
	logic [1:0]     errout_q;
	logic [2:0]     pendout_q;

	function automatic logic [W-1:0] mag(input logic [W-1:0] v);
		return v[W-1] ? (~v + 1'b1) : v;
	endfunction

	// {overflow, value} from sign and magnitude, saturating
	function automatic logic [W:0] pack(input logic neg, input logic [2*W-1:0] m);
		logic [2*W-1:0] lim;
		logic [W-1:0]   lo;
		logic           ovf;
		lim = {{W{1'b0}}, MAXV} + {{(2*W-1){1'b0}}, neg};
		ovf = (m > lim);
		lo  = ovf ? lim[W-1:0] : m[W-1:0];
		return {ovf, neg ? (~lo + 1'b1) : lo};
	endfunction

	// add/sub of stored and entry
	logic [W:0]   as_sum;
	logic         as_ovf;
	logic [W-1:0] as_val;
	always_comb begin
		if (pend_q == OP_SUB) begin
			as_sum = {stored_q[W-1], stored_q} - {entry_q[W-1], entry_q};
		end else begin
			as_sum = {stored_q[W-1], stored_q} + {entry_q[W-1], entry_q};
		end
		as_ovf = as_sum[W] ^ as_sum[W-1];
		as_val = as_ovf ? (as_sum[W] ? MINV : MAXV) : as_sum[W-1:0];
	end

	// digit entry: entry*10 + digit
	logic [W-1:0]   dg_m;
	logic [2*W-1:0] dg_m10, dg_dv;
	logic [W:0]     dg_t;
	logic [W-1:0]   dg_dvc;
	logic           dg_dvovf;
	logic [W:0]     dg_sum;
	logic           dg_sovf;
	logic [W-1:0]   dg_val;
	always_comb begin
		dg_m     = mag(entry_q);
		dg_m10   = ({{W{1'b0}}, dg_m} << 3) + ({{W{1'b0}}, dg_m} << 1);
		dg_t     = pack(entry_q[W-1], dg_m10);
		dg_dv    = {{(2*W-4){1'b0}}, cmd.digit} << F;
		dg_dvovf = (dg_dv > {{W{1'b0}}, MAXV});
		dg_dvc   = dg_dvovf ? MAXV : dg_dv[W-1:0];
		dg_sum   = {dg_t[W-1], dg_t[W-1:0]} + {1'b0, dg_dvc};
		dg_sovf  = dg_sum[W] ^ dg_sum[W-1];
		dg_val   = dg_sovf ? (dg_sum[W] ? MINV : MAXV) : dg_sum[W-1:0];
	end

	// one iteration of multiply or divide
	logic [W:0]     mul_up;
	logic [W:0]     dv_t;
	logic           dv_ge;
	logic [W:0]     dv_diff;
	logic [W:0]     mul_res, div_res;
	always_comb begin
		mul_up  = {1'b0, work_q[2*W-1:W]} + {1'b0, opnd_q};
		dv_t    = {rem_q, work_q[W+F-1]};
		dv_ge   = (dv_t >= {1'b0, opnd_q});
		dv_diff = dv_t - {1'b0, opnd_q};
		mul_res = pack(sign_q, work_q >> F);
		div_res = pack(sign_q, {{(W-F){1'b0}}, work_q[W+F-1:0]});
	end

	assign status.pending    = pend_q;
	assign status.entry_zero = (entry_q == '0);
	assign status.iter_done  = (cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q  <= '0;
			stored_q <= '0;
			hold_q   <= '0;
			pend_q   <= OP_NONE;
			err_q    <= ERR_NONE;
			cnt_q    <= '0;
			opnd_q   <= '0;
			rem_q    <= '0;
			work_q   <= '0;
			sign_q   <= 1'b0;
		end else begin
			if (cmd.clr_err) begin
				err_q <= ERR_NONE;
			end
			case (cmd.op)
				DP_DIGIT: begin
					entry_q <= dg_val;
					if (dg_t[W] || dg_dvovf || dg_sovf) begin
						err_q <= ERR_OVF;
					end
				end
				DP_CLEAR: begin
					entry_q  <= '0;
					stored_q <= '0;
					pend_q   <= OP_NONE;
					err_q    <= ERR_NONE;
				end
				DP_ADDSUB: begin
					entry_q  <= as_val;
					hold_q   <= as_val;
					stored_q <= '0;
					pend_q   <= OP_NONE;
					if (as_ovf) begin
						err_q <= ERR_OVF;
					end
				end
				DP_MUL_START: begin
					opnd_q <= mag(stored_q);
					work_q <= {{W{1'b0}}, mag(entry_q)};
					sign_q <= stored_q[W-1] ^ entry_q[W-1];
					cnt_q  <= CW'(W);
				end
				DP_DIV_START: begin
					opnd_q <= mag(entry_q);
					work_q <= {{(W-F){1'b0}}, mag(stored_q), {F{1'b0}}};
					rem_q  <= '0;
					sign_q <= stored_q[W-1] ^ entry_q[W-1];
					cnt_q  <= CW'(W + F);
				end
				DP_STEP: begin
					cnt_q <= cnt_q - 1'b1;
					if (pend_q == OP_MUL) begin
						// add when the low multiplier bit is set, then shift right
						if (work_q[0]) begin
							work_q <= {mul_up, work_q[W-1:1]};
						end else begin
							work_q <= {1'b0, work_q[2*W-1:1]};
						end
					end else begin
						rem_q  <= dv_ge ? dv_diff[W-1:0] : dv_t[W-1:0];
						work_q <= {work_q[2*W-2:0], dv_ge};
					end
				end
				DP_MUL_END, DP_DIV_END: begin
					entry_q  <= (cmd.op == DP_MUL_END) ? mul_res[W-1:0] : div_res[W-1:0];
					hold_q   <= (cmd.op == DP_MUL_END) ? mul_res[W-1:0] : div_res[W-1:0];
					stored_q <= '0;
					pend_q   <= OP_NONE;
					if ((cmd.op == DP_MUL_END) ? mul_res[W] : div_res[W]) begin
						err_q <= ERR_OVF;
					end
				end
				DP_DIVZERO: begin
					entry_q  <= '0;
					stored_q <= '0;
					pend_q   <= OP_NONE;
					err_q    <= ERR_DIV0;
				end
				DP_PUSH: begin
					stored_q <= entry_q;
					pend_q   <= cmd.new_op;
					entry_q  <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			disp_q    <= entry_q;
			last_q    <= hold_q;
			errout_q  <= err_q;
			pendout_q <= pend_q;
		end
	end

	assign display_value = disp_q;
	assign recent_result = last_q;
	assign error_status  = errout_q;
	assign pending_op    = pendout_q;
endmodule

>>> src/four_function_calculator_keys.sv
// Four-function calculator key entry, top level.
// key_in takes one ASCII key code per transaction: digits shift into the
// entry, + - * / resolve any pending operation and then start a new one,
// = resolves, C clears all but the last result, other keys only clear
// the error. Each key gives exactly one transaction on res_out with the
// entry value, last result, error and pending operation after the key.
// An operator key adds a push step to the handling of a key. A pending
// multiply adds one shift-add step per multiplier bit; a pending divide
// adds one restoring step per quotient bit.
// One key is handled at a time; key_in.ready is low from acceptance
// until the result is loaded into the output register.
// The output register holds a result while res_out.ready is low, and the
// next key is accepted meanwhile; that key waits for the slot to clear.
// Reset (arst_n low) zeroes entry, operand, last result, pending
// operation and error and drops res_out.valid.
module four_function_calculator_keys #(
	parameter int VALUE_BITS    = 48,
	parameter int FRACTION_BITS = 16
) (
	input logic        clk,
	input logic        arst_n,
	ffck_key_if.sink   key_in,
	ffck_res_if.source res_out
);
	import ffck_pkg::*;
	`include "four_function_calculator_keys_defines.svh"

	dp_cmd_t    cmd;
	dp_status_t status;

	ffck_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.key_valid (key_in.valid),
		.key_ready (key_in.ready),
		.key_code  (key_in.key_code),
		.res_valid (res_out.valid),
		.res_ready (res_out.ready),
		.cmd       (cmd),
		.status    (status)
	);

	ffck_dp #(
		.VALUE_BITS    (VALUE_BITS),
		.FRACTION_BITS (FRACTION_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.display_value (res_out.display_value),
		.recent_result (res_out.recent_result),
		.error_status  (res_out.error_status),
		.pending_op    (res_out.pending_op)
	);

	`FFCK_ASSERT_NEXT(a_one_key, key_in.valid && key_in.ready, !key_in.ready, "key accepted while busy")
	`FFCK_ASSERT_SAME(a_err_code, res_out.valid, res_out.error_status != 2'd3, "bad error code")
	`FFCK_ASSERT_SAME(a_capture_free, cmd.capture, !res_out.valid || res_out.ready, "result overwritten")
	`FFCK_ASSERT_SAME(a_iter_op, cmd.op == DP_STEP, status.pending == OP_MUL || status.pending == OP_DIV, "step without mul or div")
endmodule

>>> tb/four_function_calculator_keys_test.sv
// Self-checking testbench of the calculator key-entry block: keys in, predicted results checked.
module four_function_calculator_keys_test;
	import ffck_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int VALUE_BITS    = 48;
	localparam int FRACTION_BITS = 16;
	localparam longint VAL_MAX = (64'sd1 <<< (VALUE_BITS - 1)) - 1;
	localparam longint VAL_MIN = -VAL_MAX - 1;

	typedef struct {
		logic signed [VALUE_BITS-1:0] display;
		logic signed [VALUE_BITS-1:0] last;
		err_code_t                    err;
		op_code_t                     op;
	} calc_view_t;

	logic clk;
	logic arst_n;

	ffck_key_if key_bus ();
	ffck_res_if #(.VALUE_BITS(VALUE_BITS)) res_bus ();

	four_function_calculator_keys #(
		.VALUE_BITS(VALUE_BITS),
		.FRACTION_BITS(FRACTION_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.key_in(key_bus),
		.res_out(res_bus)
	);

	// calculator state as the block should hold it
	longint    entry_val;
	longint    operand_val;
	longint    result_val;
	op_code_t  pend_op;
	err_code_t err_now;

	calc_view_t expected_views[$];
	int  mismatches;
	int  keys_sent;
	int  views_checked;
	int  div0_seen;
	int  ovf_seen;
	bit  calm;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic longint fit_value(bit neg, logic [127:0] mag);
		logic [127:0] lim;
		lim = VAL_MAX + (neg ? 1 : 0);
		if (mag > lim) begin
			err_now = ERR_OVF;
			mag = lim;
		end
		return neg ? -longint'(mag[63:0]) : longint'(mag[63:0]);
	endfunction

	function automatic logic [63:0] magnitude(longint v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	function automatic longint clamp_sum(longint s);
		if (s > VAL_MAX) begin
			err_now = ERR_OVF;
			return VAL_MAX;
		end
		if (s < VAL_MIN) begin
			err_now = ERR_OVF;
			return VAL_MIN;
		end
		return s;
	endfunction

	function automatic void resolve_pending();
		longint r;
		logic [127:0] p;
		bit neg;
		if (pend_op == OP_NONE) return;
		neg = (operand_val < 0) != (entry_val < 0);
		case (pend_op)
			OP_ADD: r = clamp_sum(operand_val + entry_val);
			OP_SUB: r = clamp_sum(operand_val - entry_val);
			OP_MUL: begin
				p = {64'd0, magnitude(operand_val)} * {64'd0, magnitude(entry_val)};
				r = fit_value(neg, p >> FRACTION_BITS);
			end
			default: begin
				if (entry_val == 0) begin
					err_now = ERR_DIV0;
					entry_val = 0;
					pend_op = OP_NONE;
					operand_val = 0;
					return;
				end
				p = ({64'd0, magnitude(operand_val)} << FRACTION_BITS) /
					{64'd0, magnitude(entry_val)};
				r = fit_value(neg, p);
			end
		endcase
		entry_val = r;
		result_val = r;
		pend_op = OP_NONE;
		operand_val = 0;
	endfunction

	function automatic calc_view_t apply_key(logic [7:0] key);
		calc_view_t v;
		key_kind_t kind;
		op_code_t o;
		bit neg;
		err_now = ERR_NONE;
		kind = key_kind(key);
		case (kind)
			KC_DIGIT: begin
				neg = entry_val < 0;
				entry_val = fit_value(neg, {64'd0, magnitude(entry_val)} * 10);
				entry_val = clamp_sum(entry_val + (longint'(key - KEY_ZERO) << FRACTION_BITS));
			end
			KC_EQUALS: resolve_pending();
			KC_CLEAR: begin
				entry_val = 0;
				operand_val = 0;
				pend_op = OP_NONE;
			end
			KC_OPER: begin
				o = key == KEY_PLUS ? OP_ADD : key == KEY_MINUS ? OP_SUB :
					key == KEY_TIMES ? OP_MUL : OP_DIV;
				resolve_pending();
				operand_val = entry_val;
				pend_op = o;
				entry_val = 0;
			end
			default: ;
		endcase
		v.display = entry_val[VALUE_BITS-1:0];
		v.last = result_val[VALUE_BITS-1:0];
		v.err = err_now;
		v.op = pend_op;
		return v;
	endfunction

	task automatic press(logic [7:0] key);
		int gap;
		gap = calm ? 0 : $urandom_range(7);
		if (gap > 0) begin
			key_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		key_bus.valid <= 1'b1;
		key_bus.key_code <= key;
		do @(posedge clk); while (!key_bus.ready);
		expected_views.push_back(apply_key(key));
		if (expected_views[$].err == ERR_DIV0) div0_seen++;
		if (expected_views[$].err == ERR_OVF) ovf_seen++;
		keys_sent++;
	endtask

	task automatic press_string(string s);
		for (int i = 0; i < s.len(); i++) press(s[i]);
	endtask

	task automatic wait_drained();
		key_bus.valid <= 1'b0;
		while (expected_views.size() != 0) @(posedge clk);
	endtask

	// result sink: random stalls per transaction
	initial begin
		int n;
		res_bus.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			n = calm ? 0 : $urandom_range(7);
			if (n > 0) begin
				res_bus.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			res_bus.ready <= 1'b1;
			do @(posedge clk); while (!(res_bus.valid && res_bus.ready));
		end
	end

	always @(posedge clk) begin
		calc_view_t e;
		if (arst_n && res_bus.valid && res_bus.ready) begin
			if (expected_views.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transaction: display %0d", res_bus.display_value);
			end else begin
				e = expected_views.pop_front();
				views_checked++;
				if (res_bus.display_value !== e.display || res_bus.recent_result !== e.last ||
						res_bus.error_status !== e.err || res_bus.pending_op !== e.op) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp disp %0d last %0d err %0d op %0d, got %0d %0d %0d %0d",
							e.display, e.last, e.err, e.op, res_bus.display_value,
							res_bus.recent_result, res_bus.error_status, res_bus.pending_op);
				end
			end
		end
	end

	task automatic test_ignored_keys();
		press(KEY_EQUALS);
		press(8'h2E);
		press(8'h4D);
		press(8'h63);
		press(8'h00);
		press(8'hFF);
	endtask

	task automatic test_arithmetic();
		press_string("12+7-3*4/5=");
		press_string("5-8=3");
	endtask

	task automatic test_error_cases();
		press_string("4/0=");
		press_string("99999*99999=");
		press(KEY_CLEAR);
	endtask

	task automatic test_random(int count);
		int n, len, r;
		string ops;
		bit drained;
		ops = "+-*/";
		n = 0;
		drained = 1'b0;
		while (n < count) begin
			if (!drained && n >= count / 2) begin
				wait_drained();
				drained = 1'b1;
			end
			calm = ($urandom_range(9) == 0);
			r = $urandom_range(99);
			if (r < 10) begin
				press(8'($urandom_range(255)));
				n++;
			end else if (r < 14) begin
				press(KEY_CLEAR);
				n++;
			end else begin
				len = $urandom_range(19) == 0 ? $urandom_range(9, 12) : $urandom_range(0, 4);
				for (int i = 0; i < len; i++) press(8'(KEY_ZERO + $urandom_range(9)));
				press($urandom_range(3) == 0 ? KEY_EQUALS : ops[$urandom_range(3)]);
				n += len + 1;
			end
		end
		calm = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		key_bus.valid = 1'b0;
		key_bus.key_code = 8'h00;
		entry_val = 0;
		operand_val = 0;
		result_val = 0;
		pend_op = OP_NONE;
		err_now = ERR_NONE;
		calm = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_ignored_keys();
		test_arithmetic();
		test_error_cases();
		test_random(1800);
		wait_drained();
		repeat (100) @(posedge clk);
		$display("sent %0d keys, checked %0d results", keys_sent, views_checked);
		$display("division-by-zero results %0d, saturated results %0d", div0_seen, ovf_seen);
		if (mismatches == 0 && expected_views.size() == 0) begin
			$display("** four_function_calculator_keys: PASSED **");
		end else begin
			$display("** four_function_calculator_keys: FAILED **");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("timeout with %0d results outstanding", expected_views.size());
		$display("** four_function_calculator_keys: FAILED **");
		$finish;
	end

endmodule
